### rtl/core/ple_pkg.sv
// Package for the positional list engine: sizes, command and status codes,
// and the control bundle between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 6;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctl_t;

endpackage
`default_nettype wire

### rtl/core/ple_if.sv
// Channel interfaces for the positional list engine: command beat and
// result beat, each with valid/ready. Depends on ple_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ple_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic signed [ple_pkg::VAL_W-1:0] value;
  logic signed [ple_pkg::POS_W-1:0] position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink (input valid, cmd, value, position, output ready);
endinterface

interface ple_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [ple_pkg::VAL_W-1:0] out_value;
  logic [ple_pkg::IDX_W-1:0]        found_index;
  logic [ple_pkg::CNT_W-1:0]        entry_count;
  logic                             is_empty;
  logic [2:0]                       status;

  modport source (output valid, out_value, found_index, entry_count, is_empty, status,
                  input ready);
  modport sink (input valid, out_value, found_index, entry_count, is_empty, status,
                output ready);
endinterface
`default_nettype wire

### rtl/core/ple_ctrl.sv
// Controller for the positional list engine: sequences capture and commit
// of each command and owns the result valid flag. Depends on ple_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ple_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ple_pkg::ctl_t      ctl
);

  ple_pkg::state_t state;
  ple_pkg::state_t state_next;
  logic            out_valid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ple_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = ple_pkg::S_EXEC;
        end
      end
      ple_pkg::S_EXEC: begin
        if (!out_valid || out_ready) begin
          state_next = ple_pkg::S_IDLE;
        end
      end
      default: state_next = ple_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ple_pkg::S_IDLE);
    ctl.load   = in_valid && (state == ple_pkg::S_IDLE);
    ctl.commit = (state == ple_pkg::S_EXEC) && (!out_valid || out_ready);
    if (ctl.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ple_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ple_dp.sv
// Datapath for the positional list engine: row of entry cells that shift
// on insert and remove, parallel compare for search, result register.
// Depends on ple_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ple_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire ple_pkg::ctl_t                    ctl,
  input  wire logic [1:0]                       in_cmd,
  input  wire logic signed [ple_pkg::VAL_W-1:0] in_value,
  input  wire logic signed [ple_pkg::POS_W-1:0] in_position,
  output logic signed [ple_pkg::VAL_W-1:0]      out_value,
  output logic [ple_pkg::IDX_W-1:0]             found_index,
  output logic [ple_pkg::CNT_W-1:0]             entry_count,
  output logic                                  is_empty,
  output logic [2:0]                            status
);

  logic [1:0]                 cmd;
  logic [ple_pkg::VAL_W-1:0]  value;
  logic [ple_pkg::POS_W-1:0]  position;
  logic [ple_pkg::CNT_W-1:0]  count;
  logic [ple_pkg::VAL_W-1:0]  entries [ple_pkg::DEPTH];

  logic                       full;
  logic                       empty;
  logic                       single;
  logic                       pos_tail;
  logic                       pos_bad;
  logic                       pos_past;
  logic [ple_pkg::IDX_W-1:0]  last_idx;
  logic [ple_pkg::IDX_W-1:0]  ins_idx;
  logic [ple_pkg::IDX_W-1:0]  acc_idx;
  logic [ple_pkg::VAL_W-1:0]  acc_val;
  logic [ple_pkg::DEPTH-1:0]  match;
  logic                       hit;
  logic [ple_pkg::IDX_W-1:0]  hit_idx;
  logic                       do_ins;
  logic                       do_rem;
  logic [ple_pkg::CNT_W-1:0]  count_next;
  logic [ple_pkg::VAL_W-1:0]  ov_next;
  logic [ple_pkg::IDX_W-1:0]  fi_next;
  ple_pkg::status_t           st_next;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd      <= in_cmd;
      value    <= in_value;
      position <= in_position;
    end
  end

  always_comb begin
    full     = (count == ple_pkg::CNT_W'(ple_pkg::DEPTH));
    empty    = (count == '0);
    single   = (count == ple_pkg::CNT_W'(1));
    pos_tail = (position == '1);
    pos_bad  = position[ple_pkg::POS_W-1] && !pos_tail;
    pos_past = !position[ple_pkg::POS_W-1]
               && ({1'b0, position[ple_pkg::POS_W-2:0]} >= {1'b0, count});
    last_idx = ple_pkg::IDX_W'(count - ple_pkg::CNT_W'(1));
    ins_idx  = (pos_tail || pos_past) ? count[ple_pkg::IDX_W-1:0]
                                      : position[ple_pkg::IDX_W-1:0];
    if (single) begin
      acc_idx = '0;
    end else if (pos_tail) begin
      acc_idx = last_idx;
    end else begin
      acc_idx = position[ple_pkg::IDX_W-1:0];
    end
    acc_val = entries[acc_idx];
  end

  always_comb begin
    for (int i = 0; i < ple_pkg::DEPTH; i++) begin
      match[i] = (entries[i] == value) && (ple_pkg::CNT_W'(i) < count);
    end
    hit     = |match;
    hit_idx = '0;
    for (int i = ple_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = ple_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    count_next = count;
    ov_next    = '0;
    fi_next    = '0;
    st_next    = ple_pkg::ST_OK;
    unique case (ple_pkg::cmd_t'(cmd))
      ple_pkg::CMD_INSERT: begin
        if (full) begin
          st_next = ple_pkg::ST_FULL;
        end else if (pos_bad) begin
          st_next = ple_pkg::ST_RANGE;
        end else begin
          do_ins     = 1'b1;
          count_next = count + ple_pkg::CNT_W'(1);
        end
      end
      ple_pkg::CMD_REMOVE: begin
        if (empty) begin
          st_next = ple_pkg::ST_EMPTY;
        end else if (!single && (pos_bad || pos_past)) begin
          st_next = ple_pkg::ST_RANGE;
        end else begin
          do_rem     = 1'b1;
          ov_next    = acc_val;
          count_next = count - ple_pkg::CNT_W'(1);
        end
      end
      ple_pkg::CMD_READ: begin
        if (empty) begin
          st_next = ple_pkg::ST_EMPTY;
        end else if (pos_bad || pos_past) begin
          st_next = ple_pkg::ST_RANGE;
        end else begin
          ov_next = acc_val;
        end
      end
      ple_pkg::CMD_SEARCH: begin
        if (hit) begin
          fi_next = hit_idx;
        end else begin
          st_next = ple_pkg::ST_NOTFOUND;
        end
      end
      default: st_next = ple_pkg::ST_OK;
    endcase
  end

  for (genvar g = 0; g < ple_pkg::DEPTH; g++) begin : g_cell
    logic [ple_pkg::VAL_W-1:0] from_prev;
    logic [ple_pkg::VAL_W-1:0] from_next;
    if (g == 0) begin : g_head
      assign from_prev = entries[g];
    end else begin : g_body
      assign from_prev = entries[g-1];
    end
    if (g == ple_pkg::DEPTH - 1) begin : g_tail
      assign from_next = entries[g];
    end else begin : g_inner
      assign from_next = entries[g+1];
    end

    always_ff @(posedge clk) begin
      if (ctl.commit && do_ins) begin
        if (ple_pkg::IDX_W'(g) == ins_idx) begin
          entries[g] <= value;
        end else if (ple_pkg::IDX_W'(g) > ins_idx) begin
          entries[g] <= from_prev;
        end
      end else if (ctl.commit && do_rem) begin
        if (ple_pkg::IDX_W'(g) >= acc_idx) begin
          entries[g] <= from_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_value   <= ov_next;
      found_index <= fi_next;
      entry_count <= count_next;
      is_empty    <= (count_next == '0);
      status      <= st_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/positional_list_engine.sv
// Top level of the positional list engine: joins controller and datapath
// to the command and result channels. Depends on ple_pkg, ple_if, ple_ctrl, ple_dp.
// Result: the command beat is captured, then committed in the execute step once the
// result register is free; the result beat comes from that register.
// Commands pass through the capture and commit steps of the controller; a new command
// is taken only after the last one is committed, and is taken while a result waits.
// Reset: synchronous, clears the entry count and the handshake state.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine (
  input  wire logic  clk,
  input  wire logic  rst,
  ple_req_if.sink    req,
  ple_rsp_if.source  rsp
);

  ple_pkg::ctl_t ctl;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl)
  );

  ple_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .in_cmd      (req.cmd),
    .in_value    (req.value),
    .in_position (req.position),
    .out_value   (rsp.out_value),
    .found_index (rsp.found_index),
    .entry_count (rsp.entry_count),
    .is_empty    (rsp.is_empty),
    .status      (rsp.status)
  );

endmodule
`default_nettype wire

### verif/ple_list_checker.sv
// Checker for the positional list engine: watches the command and result channels,
// keeps a shadow copy of the list and compares every result beat field by field.
// Depends on ple_pkg and ple_if.
`timescale 1ns / 1ps
module ple_list_checker
  import ple_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ple_req_if   req,
  ple_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);

  typedef struct {
    logic [VAL_W-1:0] out_value;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
    status_t          status;
  } list_result_t;

  logic [VAL_W-1:0] shadow_list[$];
  list_result_t     due_results[$];

  initial mismatches = 0;
  assign outstanding = due_results.size();

  function automatic list_result_t list_apply(input cmd_t op, input logic [VAL_W-1:0] val,
                                              input logic [POS_W-1:0] raw_pos);
    list_result_t r;
    int pos;
    int cnt;
    int slot;
    r.out_value   = '0;
    r.found_index = '0;
    r.status      = ST_OK;
    pos = $signed(raw_pos);
    cnt = shadow_list.size();
    case (op)
      CMD_INSERT: begin
        if (cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else if (pos < -1) begin
          r.status = ST_RANGE;
        end else begin
          slot = (pos == -1 || pos >= cnt) ? cnt : pos;
          shadow_list.insert(slot, val);
        end
      end
      CMD_REMOVE: begin
        if (cnt == 0) begin
          r.status = ST_EMPTY;
        end else if (cnt == 1) begin
          // a lone entry goes whatever the position
          r.out_value = shadow_list[0];
          shadow_list.delete();
        end else if (pos < -1 || pos >= cnt) begin
          r.status = ST_RANGE;
        end else begin
          slot = (pos == -1) ? cnt - 1 : pos;
          r.out_value = shadow_list[slot];
          shadow_list.delete(slot);
        end
      end
      CMD_READ: begin
        if (cnt == 0) begin
          r.status = ST_EMPTY;
        end else if (pos < -1 || pos >= cnt) begin
          r.status = ST_RANGE;
        end else begin
          slot = (pos == -1) ? cnt - 1 : pos;
          r.out_value = shadow_list[slot];
        end
      end
      default: begin
        r.status = ST_NOTFOUND;
        foreach (shadow_list[i]) begin
          if (r.status == ST_NOTFOUND && shadow_list[i] == val) begin
            r.found_index = IDX_W'(i);
            r.status      = ST_OK;
          end
        end
      end
    endcase
    r.entry_count = CNT_W'(shadow_list.size());
    r.is_empty    = (shadow_list.size() == 0);
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ple_list_checker: %s expected %0h, got %0h", $realtime, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      shadow_list.delete();
      due_results.delete();
    end else begin
      if (req.valid && req.ready)
        due_results.push_back(list_apply(cmd_t'(req.cmd), req.value, req.position));
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t ple_list_checker: result beat with nothing pending, status %0d",
                     $realtime, rsp.status);
        end else begin
          want = due_results.pop_front();
          check_field("out_value", want.out_value, rsp.out_value);
          check_field("found_index", 32'(want.found_index), 32'(rsp.found_index));
          check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
          check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
          check_field("status", 32'(want.status), 32'(rsp.status));
        end
      end
    end
  end

endmodule

### verif/tb_positional_list_engine.sv
// Testbench top for the positional list engine: clock, reset, command stimulus
// and result back-pressure; checking is done by ple_list_checker.
// Depends on ple_pkg, ple_if, positional_list_engine and ple_list_checker.
`timescale 1ns / 1ps
module tb_positional_list_engine;
  import ple_pkg::*;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX, PH_LOOK} phase_t;

  localparam int RAND_ITEMS = 1300;
  localparam int CALM_TAIL  = 150;

  logic clk;
  logic rst;
  logic idle_on;
  int   mismatches;
  int   outstanding;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ple_list_checker list_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb_positional_list_engine: done, errors");
    $finish;
  end

  task automatic send_cmd(input cmd_t op, input logic [VAL_W-1:0] val, input int pos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= op;
    req_ch.value    <= val;
    req_ch.position <= POS_W'(pos);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  function automatic cmd_t pick_op(input phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  return r < 80 ? CMD_INSERT : r < 88 ? CMD_REMOVE : r < 94 ? CMD_READ : CMD_SEARCH;
      PH_DRAIN: return r < 15 ? CMD_INSERT : r < 75 ? CMD_REMOVE : r < 88 ? CMD_READ : CMD_SEARCH;
      PH_LOOK:  return r < 20 ? CMD_INSERT : r < 30 ? CMD_REMOVE : r < 65 ? CMD_READ : CMD_SEARCH;
      default:  return cmd_t'($urandom_range(0, 3));
    endcase
  endfunction

  // small values repeat often so that searches hit
  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return VAL_W'(int'($urandom_range(0, 6)) - 3);
    if (r == 4) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic int pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return int'($urandom_range(0, 17)) - 1;
    if (r < 8) return -1;
    return int'($urandom_range(0, 63)) - 32;
  endfunction

  initial begin : resp_side
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 7);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    phase_t ph;
    int     len;
    int     n;
    int     k;
    idle_on = 1'b1;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.cmd      <= CMD_INSERT;
    req_ch.value    <= '0;
    req_ch.position <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty list
    send_cmd(CMD_READ, 32'd0, 0);
    send_cmd(CMD_REMOVE, 32'd0, -1);
    send_cmd(CMD_SEARCH, 32'd0, 0);
    send_cmd(CMD_INSERT, 32'd9, -2);
    send_cmd(CMD_INSERT, 32'h7FFF_FFFF, 31);
    // lone entry taken despite a bad position
    send_cmd(CMD_REMOVE, 32'd0, -20);
    send_cmd(CMD_INSERT, 32'h8000_0000, -1);
    send_cmd(CMD_INSERT, 32'h7FFF_FFFF, 0);
    send_cmd(CMD_INSERT, 32'd0, 16);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 1);
    send_cmd(CMD_READ, 32'd0, -1);
    send_cmd(CMD_READ, 32'd0, 0);
    send_cmd(CMD_READ, 32'd0, 4);
    send_cmd(CMD_READ, 32'd0, -32);
    send_cmd(CMD_SEARCH, 32'hFFFF_FFFF, 5);
    send_cmd(CMD_SEARCH, 32'd12345, 0);
    send_cmd(CMD_REMOVE, 32'd0, 4);
    send_cmd(CMD_REMOVE, 32'd0, -3);
    send_cmd(CMD_REMOVE, 32'd0, 1);
    send_cmd(CMD_REMOVE, 32'd0, -1);
    send_cmd(CMD_REMOVE, 32'd0, 0);

    n = 0;
    while (n < RAND_ITEMS) begin
      ph      = phase_t'($urandom_range(0, 3));
      len     = $urandom_range(24, 48);
      idle_on = $urandom_range(0, 9) < 7;
      for (k = 0; k < len && n < RAND_ITEMS; k++) begin
        if (RAND_ITEMS - n <= CALM_TAIL) idle_on = 1'b0;
        send_cmd(pick_op(ph), pick_value(), pick_pos());
        n++;
      end
    end
    req_ch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_positional_list_engine: done, clean");
    end else begin
      $display("tb_positional_list_engine: done, errors");
    end
    $finish;
  end

endmodule
